// ----- hdl/port_knock_packet_filter_defines.svh -----
// Assertion macros for the port knocking packet filter
`ifndef PORT_KNOCK_PACKET_FILTER_DEFINES_SVH
`define PORT_KNOCK_PACKET_FILTER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PKF_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pkf assertion failed");

// next-cycle implication, disabled during reset
`define PKF_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pkf assertion failed");

`endif

// ----- hdl/pkf_pkg.sv -----
// Types, constants and helpers shared by the port knocking filter
`timescale 1ns / 1ps
package pkf_pkg;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_KNOCK_FIRST  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_KNOCK_SECOND = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_KNOCK_THIRD  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_HIDDEN_ZERO  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_HIDDEN_ONE   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_HIDDEN_TWO   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_HIDDEN_THREE = 3'd6;

  localparam logic [15:0] KNOCK_FIRST_RESET  = 16'd2345;
  localparam logic [15:0] KNOCK_SECOND_RESET = 16'd3456;
  localparam logic [15:0] KNOCK_THIRD_RESET  = 16'd4567;
  localparam logic [16:0] HIDDEN_EMPTY       = 17'h10000;

  localparam logic [1:0] KNOCK_DONE = 2'd3;

  typedef enum logic [2:0] {
    OUT_PASS     = 3'd0,
    OUT_ADVANCED = 3'd1,
    OUT_MISMATCH = 3'd2,
    OUT_GRANTED  = 3'd3,
    OUT_REFUSED  = 3'd4,
    OUT_FULL     = 3'd5
  } outcome_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_SCAN,
    ST_DECIDE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [15:0] knock_first;
    logic [15:0] knock_second;
    logic [15:0] knock_third;
    logic [16:0] hidden_zero;
    logic [16:0] hidden_one;
    logic [16:0] hidden_two;
    logic [16:0] hidden_three;
  } cfg_t;

  typedef struct packed {
    logic        family;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [1:0]  progress;
  } entry_t;

  typedef struct packed {
    logic scan_clear;
    logic rd_en;
    logic wr_en;
    logic wr_keep;
  } tbl_ctl_t;

  typedef struct packed {
    logic       rd_live;
    logic       found;
    logic       free_found;
    logic [1:0] hit_prog;
  } tbl_st_t;

  function automatic logic [15:0] knock_at(cfg_t cfg, logic [1:0] step);
    logic [15:0] port;
    case (step)
      2'd0:    port = cfg.knock_first;
      2'd1:    port = cfg.knock_second;
      default: port = cfg.knock_third;
    endcase
    return port;
  endfunction

  function automatic logic slot_live(logic [16:0] slot);
    return !slot[16];
  endfunction

  function automatic logic slot_hit(logic [16:0] slot, logic [15:0] port);
    return !slot[16] && (slot[15:0] == port);
  endfunction

endpackage

// ----- hdl/pkf_if.sv -----
// Item and result channel interfaces of the port knocking filter
`timescale 1ns / 1ps
interface pkf_item_if;
  logic        valid;
  logic        ready;
  logic        is_ipv6;
  logic        is_tcp;
  logic [63:0] src_addr_high;
  logic [63:0] src_addr_low;
  logic [15:0] dest_port;

  modport source (output valid, is_ipv6, is_tcp, src_addr_high, src_addr_low, dest_port,
                  input ready);
  modport sink (input valid, is_ipv6, is_tcp, src_addr_high, src_addr_low, dest_port,
                output ready);
endinterface

interface pkf_result_if;
  logic       valid;
  logic       ready;
  logic       drop_with_reset;
  logic [2:0] outcome;

  modport source (output valid, drop_with_reset, outcome, input ready);
  modport sink (input valid, drop_with_reset, outcome, output ready);
endinterface

// ----- hdl/port_knock_packet_filter.sv -----
// Top level of the port knocking packet filter with its sequencer
//
// item channel: one packet summary (family, TCP flag, source address,
// destination port). result channel: drop_with_reset and outcome, one
// result per item, in order. Both use valid/ready; an item or result
// moves at a clock edge with valid and ready high.
// Configuration goes through the APB port: knock ports at 0x00..0x08,
// hidden slots at 0x0C..0x18; write only while no item is in flight.
// An item that needs no table lookup (no hidden port, not TCP, or a port
// that is neither knock nor hidden) goes from CLASSIFY straight to FINISH.
// Any other item scans the sender table through one compare unit, one
// entry per cycle, then passes through DECIDE to FINISH.
// One item is worked on at a time; the next can be accepted in the cycle
// after its result is loaded. The result sits in an output register; the
// next item is accepted while it waits, and the sequencer holds a
// finished result until the register is free.
// Reset (rst, synchronous) clears the sender valid bits, loads the
// default knock ports 2345, 3456, 4567 and empties all hidden slots.
`timescale 1ns / 1ps
`include "port_knock_packet_filter_defines.svh"
module port_knock_packet_filter #(
  parameter int SENDER_ENTRIES = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  pkf_item_if.sink                         item,
  pkf_result_if.source                     result,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pkf_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [pkf_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [pkf_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);

  localparam int AW = (SENDER_ENTRIES > 1) ? $clog2(SENDER_ENTRIES) : 1;
  localparam int CW = $clog2(SENDER_ENTRIES + 1);
  localparam logic [CW-1:0] LAST_CNT = CW'(SENDER_ENTRIES);

  pkf_pkg::cfg_t        cfg;
  pkf_pkg::state_t      state, state_next;
  pkf_pkg::tbl_ctl_t    tbl_ctl;
  pkf_pkg::tbl_st_t     tbl_st;
  pkf_pkg::outcome_t    res_outcome, res_outcome_next, out_outcome;

  logic [CW-1:0]  cnt, cnt_next;
  logic           key_fam, key_tcp;
  logic [63:0]    key_hi, key_lo;
  logic [15:0]    key_port;
  logic           res_drop, res_drop_next, out_drop, out_valid;
  logic           in_ready, load_out;
  logic           any_hidden, port_hidden, is_knock;
  logic [AW-1:0]  hit_idx, free_idx, wr_addr;
  logic [1:0]     wr_prog, cur_prog;

  assign pready = 1'b1;

  pkf_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  pkf_sender_table #(
    .SENDER_ENTRIES (SENDER_ENTRIES),
    .AW             (AW)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .ctl      (tbl_ctl),
    .rd_addr  (cnt[AW-1:0]),
    .wr_addr  (wr_addr),
    .wr_prog  (wr_prog),
    .key_fam  (key_fam),
    .key_hi   (key_hi),
    .key_lo   (key_lo),
    .st       (tbl_st),
    .hit_idx  (hit_idx),
    .free_idx (free_idx)
  );

  // capture and normalize the sender key
  always_ff @(posedge clk) begin
    if (item.valid && in_ready) begin
      key_fam  <= item.is_ipv6;
      key_tcp  <= item.is_tcp;
      key_hi   <= item.is_ipv6 ? item.src_addr_high : 64'd0;
      key_lo   <= item.is_ipv6 ? item.src_addr_low : {32'd0, item.src_addr_low[31:0]};
      key_port <= item.dest_port;
    end
  end

  assign any_hidden = pkf_pkg::slot_live(cfg.hidden_zero) ||
                      pkf_pkg::slot_live(cfg.hidden_one) ||
                      pkf_pkg::slot_live(cfg.hidden_two) ||
                      pkf_pkg::slot_live(cfg.hidden_three);
  assign port_hidden = pkf_pkg::slot_hit(cfg.hidden_zero, key_port) ||
                       pkf_pkg::slot_hit(cfg.hidden_one, key_port) ||
                       pkf_pkg::slot_hit(cfg.hidden_two, key_port) ||
                       pkf_pkg::slot_hit(cfg.hidden_three, key_port);
  assign is_knock = (key_port == cfg.knock_first) || (key_port == cfg.knock_second) ||
                    (key_port == cfg.knock_third);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pkf_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    res_drop    <= res_drop_next;
    res_outcome <= res_outcome_next;
  end

  always_comb begin
    state_next       = state;
    cnt_next         = cnt;
    in_ready         = 1'b0;
    load_out         = 1'b0;
    tbl_ctl          = '0;
    res_drop_next    = res_drop;
    res_outcome_next = res_outcome;
    cur_prog         = tbl_st.found ? tbl_st.hit_prog : 2'd0;
    wr_addr          = tbl_st.found ? hit_idx : free_idx;
    wr_prog          = cur_prog;
    case (state)
      pkf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (item.valid) begin
          state_next = pkf_pkg::ST_CLASSIFY;
        end
      end
      pkf_pkg::ST_CLASSIFY: begin
        if (!any_hidden || !key_tcp || (!port_hidden && !is_knock)) begin
          res_drop_next    = 1'b0;
          res_outcome_next = pkf_pkg::OUT_PASS;
          state_next       = pkf_pkg::ST_FINISH;
        end else begin
          tbl_ctl.scan_clear = 1'b1;
          cnt_next           = '0;
          state_next         = pkf_pkg::ST_SCAN;
        end
      end
      pkf_pkg::ST_SCAN: begin
        if (cnt != LAST_CNT) begin
          tbl_ctl.rd_en = 1'b1;
          cnt_next      = cnt + 1'b1;
        end else if (!tbl_st.rd_live) begin
          state_next = pkf_pkg::ST_DECIDE;
        end
      end
      pkf_pkg::ST_DECIDE: begin
        state_next = pkf_pkg::ST_FINISH;
        if (port_hidden) begin
          if (tbl_st.found && (tbl_st.hit_prog == pkf_pkg::KNOCK_DONE)) begin
            res_drop_next    = 1'b0;
            res_outcome_next = pkf_pkg::OUT_GRANTED;
          end else begin
            res_drop_next    = 1'b1;
            res_outcome_next = pkf_pkg::OUT_REFUSED;
          end
        end else if (!tbl_st.found && !tbl_st.free_found) begin
          res_drop_next    = 1'b1;
          res_outcome_next = pkf_pkg::OUT_FULL;
        end else begin
          tbl_ctl.wr_en = 1'b1;
          res_drop_next = 1'b1;
          if ((cur_prog != pkf_pkg::KNOCK_DONE) &&
              (key_port == pkf_pkg::knock_at(cfg, cur_prog))) begin
            tbl_ctl.wr_keep  = 1'b1;
            wr_prog          = cur_prog + 2'd1;
            res_outcome_next = pkf_pkg::OUT_ADVANCED;
          end else begin
            res_outcome_next = pkf_pkg::OUT_MISMATCH;
          end
        end
      end
      pkf_pkg::ST_FINISH: begin
        if (!out_valid || result.ready) begin
          load_out   = 1'b1;
          state_next = pkf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pkf_pkg::ST_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_drop    <= res_drop;
      out_outcome <= res_outcome;
    end
  end

  assign item.ready             = in_ready;
  assign result.valid           = out_valid;
  assign result.drop_with_reset = out_drop;
  assign result.outcome         = out_outcome;

  `PKF_ASSERT_NEXT(a_accept_classify, clk, rst, item.valid && item.ready, state == pkf_pkg::ST_CLASSIFY)
  `PKF_ASSERT_IMPL(a_write_in_decide, clk, rst, tbl_ctl.wr_en, state == pkf_pkg::ST_DECIDE)
  `PKF_ASSERT_IMPL(a_load_slot_free, clk, rst, load_out, !out_valid || result.ready)
  `PKF_ASSERT_IMPL(a_scan_drained, clk, rst, state == pkf_pkg::ST_DECIDE, !tbl_st.rd_live)

endmodule

// ----- hdl/pkf_cfg_regs.sv -----
// APB configuration registers: knock ports and hidden port slots
`timescale 1ns / 1ps
module pkf_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pkf_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [pkf_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [pkf_pkg::APB_DATA_W-1:0]   prdata,
  output pkf_pkg::cfg_t                    cfg
);

  logic                              wr;
  logic [pkf_pkg::REG_IDX_W-1:0]     reg_idx;

  assign wr      = psel && penable && pwrite;
  assign reg_idx = paddr[pkf_pkg::APB_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.knock_first  <= pkf_pkg::KNOCK_FIRST_RESET;
      cfg.knock_second <= pkf_pkg::KNOCK_SECOND_RESET;
      cfg.knock_third  <= pkf_pkg::KNOCK_THIRD_RESET;
      cfg.hidden_zero  <= pkf_pkg::HIDDEN_EMPTY;
      cfg.hidden_one   <= pkf_pkg::HIDDEN_EMPTY;
      cfg.hidden_two   <= pkf_pkg::HIDDEN_EMPTY;
      cfg.hidden_three <= pkf_pkg::HIDDEN_EMPTY;
    end else if (wr) begin
      case (reg_idx)
        pkf_pkg::REG_KNOCK_FIRST:  cfg.knock_first  <= pwdata[15:0];
        pkf_pkg::REG_KNOCK_SECOND: cfg.knock_second <= pwdata[15:0];
        pkf_pkg::REG_KNOCK_THIRD:  cfg.knock_third  <= pwdata[15:0];
        pkf_pkg::REG_HIDDEN_ZERO:  cfg.hidden_zero  <= pwdata[16:0];
        pkf_pkg::REG_HIDDEN_ONE:   cfg.hidden_one   <= pwdata[16:0];
        pkf_pkg::REG_HIDDEN_TWO:   cfg.hidden_two   <= pwdata[16:0];
        pkf_pkg::REG_HIDDEN_THREE: cfg.hidden_three <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      pkf_pkg::REG_KNOCK_FIRST:  prdata = {16'd0, cfg.knock_first};
      pkf_pkg::REG_KNOCK_SECOND: prdata = {16'd0, cfg.knock_second};
      pkf_pkg::REG_KNOCK_THIRD:  prdata = {16'd0, cfg.knock_third};
      pkf_pkg::REG_HIDDEN_ZERO:  prdata = {15'd0, cfg.hidden_zero};
      pkf_pkg::REG_HIDDEN_ONE:   prdata = {15'd0, cfg.hidden_one};
      pkf_pkg::REG_HIDDEN_TWO:   prdata = {15'd0, cfg.hidden_two};
      pkf_pkg::REG_HIDDEN_THREE: prdata = {15'd0, cfg.hidden_three};
      default:                   prdata = '0;
    endcase
  end

endmodule

// ----- hdl/pkf_sender_table.sv -----
// Sender table memory with valid bits and the shared entry compare unit
`timescale 1ns / 1ps
module pkf_sender_table #(
  parameter int SENDER_ENTRIES = 16,
  parameter int AW = (SENDER_ENTRIES > 1) ? $clog2(SENDER_ENTRIES) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  pkf_pkg::tbl_ctl_t     ctl,
  input  logic [AW-1:0]         rd_addr,
  input  logic [AW-1:0]         wr_addr,
  input  logic [1:0]            wr_prog,
  input  logic                  key_fam,
  input  logic [63:0]           key_hi,
  input  logic [63:0]           key_lo,
  output pkf_pkg::tbl_st_t      st,
  output logic [AW-1:0]         hit_idx,
  output logic [AW-1:0]         free_idx
);

  pkf_pkg::entry_t             mem [SENDER_ENTRIES];
  pkf_pkg::entry_t             rd_rec;
  pkf_pkg::entry_t             wr_rec;
  logic [SENDER_ENTRIES-1:0]   valid;
  logic [AW-1:0]               rd_idx;
  logic                        match;

  assign wr_rec = '{family: key_fam, addr_high: key_hi, addr_low: key_lo,
                    progress: wr_prog};

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_rec;
    end
    if (ctl.rd_en) begin
      rd_rec <= mem[rd_addr];
      rd_idx <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ctl.wr_en) begin
      valid[wr_addr] <= ctl.wr_keep;
    end
  end

  assign match = valid[rd_idx] && (rd_rec.family == key_fam) &&
                 (rd_rec.addr_high == key_hi) && (rd_rec.addr_low == key_lo);

  always_ff @(posedge clk) begin
    if (rst) begin
      st.rd_live    <= 1'b0;
      st.found      <= 1'b0;
      st.free_found <= 1'b0;
    end else begin
      st.rd_live <= ctl.rd_en;
      if (ctl.scan_clear) begin
        st.found      <= 1'b0;
        st.free_found <= 1'b0;
      end else begin
        if (st.rd_live && match && !st.found) begin
          st.found <= 1'b1;
        end
        if (ctl.rd_en && !valid[rd_addr] && !st.free_found) begin
          st.free_found <= 1'b1;
        end
      end
    end
    if (st.rd_live && match && !st.found) begin
      hit_idx     <= rd_idx;
      st.hit_prog <= rd_rec.progress;
    end
    if (ctl.rd_en && !valid[rd_addr] && !st.free_found) begin
      free_idx <= rd_addr;
    end
  end

endmodule
